>>> rtl/tcc_pkg.sv
// Package for the text console engine: geometry, widths, codes and the
// request/response/control types. No dependencies.
package tcc_pkg;

  // Screen geometry
  localparam int COLUMNS = 80;
  localparam int ROWS    = 25;
  localparam int CELLS   = COLUMNS * ROWS;

  // Widths
  localparam int ADDR_W = $clog2(CELLS);
  localparam int CUR_W  = $clog2(COLUMNS + 1);
  localparam int COL_W  = 7;
  localparam int ROW_W  = 5;
  localparam int CHR_W  = 8;
  localparam int CELL_W = 16;

  // Attribute after reset
  localparam logic [CHR_W-1:0] TEXT_COLOR_RST = 8'd7;

  // Character codes
  localparam logic [CHR_W-1:0] CH_NEWLINE   = 8'd10;
  localparam logic [CHR_W-1:0] CH_RETURN    = 8'd13;
  localparam logic [CHR_W-1:0] CH_BACKSPACE = 8'd8;
  localparam logic [CHR_W-1:0] CH_SPACE     = 8'd32;

  // Request opcodes
  typedef enum logic [1:0] {
    OP_PUT   = 2'd0,
    OP_PLOT  = 2'd1,
    OP_CLEAR = 2'd2,
    OP_READ  = 2'd3
  } op_e;

  typedef struct packed {
    logic [1:0]       opcode;
    logic [CHR_W-1:0] char_code;
    logic [COL_W-1:0] column;
    logic [ROW_W-1:0] row;
  } req_t;

  typedef struct packed {
    logic [COL_W-1:0]  cursor_column;
    logic [ROW_W-1:0]  cursor_row;
    logic [CELL_W-1:0] cell_value;
  } rsp_t;

  // Controller to datapath commands
  typedef struct packed {
    logic latch;       // capture the request
    logic cnt_zero;    // sweep counter to first cell
    logic cnt_lastrow; // sweep counter to first cell of the last row
    logic fill_step;   // write the fill value at the counter, advance
    logic fill_zero;   // fill value is zero instead of a blank
    logic copy_step;   // read one row below the counter, write back next cycle
    logic apply;       // cursor update and single cell access
    logic finish;      // load response and strobe it
  } ctl_t;

  // Datapath to controller status
  typedef struct packed {
    op_e  op;
    logic need_scroll;
    logic fill_last;
    logic copy_last;
  } sts_t;

endpackage

>>> rtl/tcc_ram.sv
// Generic single write, single read RAM with registered read data.
// No dependencies.
module tcc_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/tcc_ctrl.sv
// Sequencer for the text console: reset clearing pass, scroll, clear and
// single-cell steps. Depends on tcc_pkg.
module tcc_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  output logic          busy_o,
  input  tcc_pkg::sts_t sts_i,
  output tcc_pkg::ctl_t ctl_o
);

  typedef enum logic [8:0] {
    S_INIT   = 9'b000000001,
    S_IDLE   = 9'b000000010,
    S_EXEC   = 9'b000000100,
    S_SCROLL = 9'b000001000,
    S_DRAIN  = 9'b000010000,
    S_BLANK  = 9'b000100000,
    S_APPLY  = 9'b001000000,
    S_FILL   = 9'b010000000,
    S_FINISH = 9'b100000000
  } state_e;

  state_e state_q, state_d;

  // Next state and commands
  always_comb begin
    state_d = state_q;
    ctl_o   = '0;
    unique case (state_q)
      S_INIT: begin
        ctl_o.fill_step = 1'b1;
        ctl_o.fill_zero = 1'b1;
        if (sts_i.fill_last) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (start_i) begin
          ctl_o.latch = 1'b1;
          state_d     = S_EXEC;
        end
      end
      S_EXEC: begin
        ctl_o.cnt_zero = 1'b1;
        state_d = sts_i.need_scroll ? S_SCROLL : S_APPLY;
      end
      S_SCROLL: begin
        ctl_o.copy_step = 1'b1;
        if (sts_i.copy_last) state_d = S_DRAIN;
      end
      S_DRAIN: begin
        // last copied cell is written this cycle
        ctl_o.cnt_lastrow = 1'b1;
        state_d = S_BLANK;
      end
      S_BLANK: begin
        ctl_o.fill_step = 1'b1;
        if (sts_i.fill_last) state_d = S_APPLY;
      end
      S_APPLY: begin
        ctl_o.apply = 1'b1;
        state_d = (sts_i.op == tcc_pkg::OP_CLEAR) ? S_FILL : S_FINISH;
      end
      S_FILL: begin
        ctl_o.fill_step = 1'b1;
        if (sts_i.fill_last) state_d = S_FINISH;
      end
      S_FINISH: begin
        ctl_o.finish = 1'b1;
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_INIT;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy_o = (state_q != S_IDLE);

endmodule

>>> rtl/tcc_dp.sv
// Datapath for the text console: screen store, cursor, sweep counter and
// response register. Depends on tcc_pkg and tcc_ram.
module tcc_dp (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  tcc_pkg::req_t             req_i,
  input  logic                      cfg_we_i,
  input  logic [tcc_pkg::CHR_W-1:0] cfg_data_i,
  input  tcc_pkg::ctl_t             ctl_i,
  output tcc_pkg::sts_t             sts_o,
  output logic                      done_o,
  output tcc_pkg::rsp_t             rsp_o
);

  localparam int AW = tcc_pkg::ADDR_W;
  localparam int CW = tcc_pkg::CUR_W;
  localparam int RW = tcc_pkg::ROW_W;
  localparam logic [AW-1:0] COLS_A     = AW'(tcc_pkg::COLUMNS);
  localparam logic [AW-1:0] LAST_CELL  = AW'(tcc_pkg::CELLS - 1);
  localparam logic [AW-1:0] LAST_COPY  = AW'(tcc_pkg::CELLS - tcc_pkg::COLUMNS - 1);
  localparam logic [AW-1:0] LAST_ROW_A = AW'(tcc_pkg::CELLS - tcc_pkg::COLUMNS);
  localparam logic [CW-1:0] COLS_C     = CW'(tcc_pkg::COLUMNS);
  localparam logic [RW-1:0] BOTTOM     = RW'(tcc_pkg::ROWS - 1);

  tcc_pkg::req_t             req_q;
  logic [tcc_pkg::CHR_W-1:0] color_q;
  logic [CW-1:0]             col_q, col_d;
  logic [RW-1:0]             line_q, line_d;
  logic [AW-1:0]             cnt_q;
  logic                      cp_pend_q;
  logic [AW-1:0]             cp_addr_q;
  logic                      done_q;
  tcc_pkg::rsp_t             rsp_q;

  tcc_pkg::op_e               op;
  logic                       on_screen;
  logic                       wrap;
  logic [RW-1:0]              adv_line;
  logic [RW-1:0]              eff_line;
  logic [CW-1:0]              eff_col;
  logic [tcc_pkg::CELL_W-1:0] blank;
  logic [RW-1:0]              a_row;
  logic [AW-1:0]              a_col;
  logic [AW-1:0]              cell_addr;
  logic                       cell_we;
  logic [tcc_pkg::CELL_W-1:0] cell_data;
  logic                       ram_we;
  logic [AW-1:0]              ram_waddr;
  logic [tcc_pkg::CELL_W-1:0] ram_wdata;
  logic [AW-1:0]              ram_raddr;
  logic [tcc_pkg::CELL_W-1:0] ram_rdata;

  // Request decode
  assign op        = tcc_pkg::op_e'(req_q.opcode);
  assign on_screen = ({1'b0, req_q.column} < 8'(tcc_pkg::COLUMNS)) &&
                     ({1'b0, req_q.row} < 6'(tcc_pkg::ROWS));
  assign wrap      = (col_q >= COLS_C);
  assign adv_line  = (line_q == BOTTOM) ? line_q : line_q + 1'b1;
  assign eff_line  = wrap ? adv_line : line_q;
  assign eff_col   = wrap ? '0 : col_q;
  assign blank     = {color_q, tcc_pkg::CH_SPACE};

  // Status: scroll needed when a line advance happens on the bottom row
  always_comb begin
    sts_o.op          = op;
    sts_o.need_scroll = (op == tcc_pkg::OP_PUT) && (line_q == BOTTOM) &&
                        ((req_q.char_code == tcc_pkg::CH_NEWLINE) ||
                         (wrap && (req_q.char_code != tcc_pkg::CH_RETURN) &&
                          (req_q.char_code != tcc_pkg::CH_BACKSPACE)));
    sts_o.fill_last   = (cnt_q == LAST_CELL);
    sts_o.copy_last   = (cnt_q == LAST_COPY);
  end

  // Cursor update and single cell access
  always_comb begin
    col_d     = col_q;
    line_d    = line_q;
    a_row     = line_q;
    a_col     = AW'(col_q);
    cell_we   = 1'b0;
    cell_data = blank;
    unique case (op)
      tcc_pkg::OP_PUT: begin
        priority if (req_q.char_code == tcc_pkg::CH_NEWLINE) begin
          col_d  = '0;
          line_d = adv_line;
        end else if (req_q.char_code == tcc_pkg::CH_RETURN) begin
          col_d = '0;
        end else if (req_q.char_code == tcc_pkg::CH_BACKSPACE) begin
          if (col_q != '0) begin
            col_d   = col_q - 1'b1;
            a_col   = AW'(col_q - 1'b1);
            cell_we = 1'b1;
          end
        end else begin
          line_d    = eff_line;
          col_d     = eff_col + 1'b1;
          a_row     = eff_line;
          a_col     = AW'(eff_col);
          cell_we   = 1'b1;
          cell_data = {color_q, req_q.char_code};
        end
      end
      tcc_pkg::OP_PLOT: begin
        a_row     = req_q.row;
        a_col     = AW'(req_q.column);
        cell_we   = on_screen;
        cell_data = {color_q, req_q.char_code};
      end
      tcc_pkg::OP_CLEAR: begin
        col_d  = '0;
        line_d = '0;
      end
      tcc_pkg::OP_READ: begin
        a_row = req_q.row;
        a_col = AW'(req_q.column);
      end
      default: ;
    endcase
  end

  assign cell_addr = AW'(a_row) * COLS_A + a_col;

  // Store port selection; controller keeps the writers apart
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = cell_addr;
    ram_wdata = cell_data;
    priority if (cp_pend_q) begin
      ram_we    = 1'b1;
      ram_waddr = cp_addr_q;
      ram_wdata = ram_rdata;
    end else if (ctl_i.fill_step) begin
      ram_we    = 1'b1;
      ram_waddr = cnt_q;
      ram_wdata = ctl_i.fill_zero ? '0 : blank;
    end else if (ctl_i.apply) begin
      ram_we    = cell_we;
    end
  end

  assign ram_raddr = ctl_i.copy_step ? cnt_q + COLS_A : cell_addr;

  tcc_ram #(
    .WIDTH (tcc_pkg::CELL_W),
    .DEPTH (tcc_pkg::CELLS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      color_q   <= tcc_pkg::TEXT_COLOR_RST;
      col_q     <= '0;
      line_q    <= '0;
      cnt_q     <= '0;
      cp_pend_q <= 1'b0;
      done_q    <= 1'b0;
    end else begin
      if (cfg_we_i) color_q <= cfg_data_i;
      if (ctl_i.apply) begin
        col_q  <= col_d;
        line_q <= line_d;
      end
      priority if (ctl_i.cnt_zero) begin
        cnt_q <= '0;
      end else if (ctl_i.cnt_lastrow) begin
        cnt_q <= LAST_ROW_A;
      end else if (ctl_i.fill_step || ctl_i.copy_step) begin
        cnt_q <= cnt_q + 1'b1;
      end
      cp_pend_q <= ctl_i.copy_step;
      done_q    <= ctl_i.finish;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (ctl_i.latch) req_q <= req_i;
    if (ctl_i.copy_step) cp_addr_q <= cnt_q;
    if (ctl_i.finish) begin
      rsp_q.cursor_column <= tcc_pkg::COL_W'(col_q);
      rsp_q.cursor_row    <= line_q;
      rsp_q.cell_value    <= ((op == tcc_pkg::OP_READ) && on_screen) ? ram_rdata : '0;
    end
  end

  assign done_o = done_q;
  assign rsp_o  = rsp_q;

endmodule

>>> rtl/text_console_cursor_scroll.sv
// Top level of the text console engine: sequencer plus datapath.
// Depends on tcc_pkg, tcc_ctrl, tcc_dp (and tcc_ram below it).
//
//  channel   | ports                      | handshake
//  ----------+----------------------------+------------------------------
//  request   | req_i (tcc_pkg::req_t)     | taken when start_i & !busy_o
//  response  | rsp_o (tcc_pkg::rsp_t)     | one-cycle strobe on done_o
//  config    | cfg_data_i (text color)    | written when cfg_we_i
//
// A put, plot or read request that does not scroll steps from accept through
// EXEC, APPLY and FINISH back to IDLE; the done_o strobe falls in the cycle
// busy_o drops. A scroll adds copy, drain and a blank of the last row, and a
// clear writes a blank to every cell, both through the one write port of the store.
// After reset a clearing pass zeroes the store; busy_o stays high meanwhile,
// config writes are still taken. The receiver cannot stall: done_o is high
// for one cycle only, while rsp_o holds the response until the next one.
module text_console_cursor_scroll (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  output logic                      busy_o,
  input  tcc_pkg::req_t             req_i,
  output logic                      done_o,
  output tcc_pkg::rsp_t             rsp_o,
  input  logic                      cfg_we_i,
  input  logic [tcc_pkg::CHR_W-1:0] cfg_data_i
);

  tcc_pkg::ctl_t ctl;
  tcc_pkg::sts_t sts;

  tcc_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .busy_o  (busy_o),
    .sts_i   (sts),
    .ctl_o   (ctl)
  );

  tcc_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (req_i),
    .cfg_we_i   (cfg_we_i),
    .cfg_data_i (cfg_data_i),
    .ctl_i      (ctl),
    .sts_o      (sts),
    .done_o     (done_o),
    .rsp_o      (rsp_o)
  );

endmodule
